[hdl/lcg_pkg.sv]
// Package for the lattice cluster growth core: codes, coordinate type, geometry tables.
// No dependencies; imported by lcg_emit and the top level.
package lcg_pkg;

	localparam int CoordW = 5;

	typedef struct packed {
		logic [CoordW-1:0] z;
		logic [CoordW-1:0] y;
		logic [CoordW-1:0] x;
	} coord_t;

	typedef enum logic [1:0] {
		OP_GROW = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2,
		OP_RSVD = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_REFUSED = 2'd1,
		STS_NOTDONE = 2'd2,
		STS_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_PICK_WT,
		S_LIN,
		S_LIN2,
		S_PLACE,
		S_CMP,
		S_NB_RD,
		S_NB_WR,
		S_POP_WT,
		S_EMIT,
		S_FIN
	} state_t;

	function automatic int calc_max_half(input int maxh, input int lat, input int cells);
		int r;
		r = 1;
		for (int h = 1; h <= 7; h++) begin
			if (h <= maxh && (4*h+1)*(4*h+1)*(4*h+1) <= lat && 4*h*h*h <= cells) begin
				r = h;
			end
		end
		return r;
	endfunction

	function automatic logic [9:0] side_sq(input logic [2:0] h);
		logic [9:0] r;
		case (h)
			3'd2: r = 10'd81;
			3'd3: r = 10'd169;
			3'd4: r = 10'd289;
			3'd5: r = 10'd441;
			3'd6: r = 10'd625;
			3'd7: r = 10'd841;
			default: r = 10'd25;
		endcase
		return r;
	endfunction

	function automatic logic [10:0] grain_target(input logic [2:0] h);
		logic [10:0] r;
		case (h)
			3'd2: r = 11'd32;
			3'd3: r = 11'd108;
			3'd4: r = 11'd256;
			3'd5: r = 11'd500;
			3'd6: r = 11'd864;
			3'd7: r = 11'd1372;
			default: r = 11'd4;
		endcase
		return r;
	endfunction

endpackage

[hdl/lcg_req_if.sv]
// Request channel of the lattice cluster growth core: valid, ready and command payload.
// No dependencies.
interface lcg_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [30:0] random_word;

	modport source (output valid, opcode, random_word, input ready);
	modport sink (input valid, opcode, random_word, output ready);
endinterface

[hdl/lcg_rsp_if.sv]
// Response channel of the lattice cluster growth core: valid, ready and cell payload.
// No dependencies.
interface lcg_rsp_if;
	logic              valid;
	logic              ready;
	logic signed [4:0] cell_x;
	logic signed [4:0] cell_y;
	logic signed [4:0] cell_z;
	logic [9:0]        dist_squared;
	logic [10:0]       cells_left;
	logic              empty_flag;
	logic [1:0]        status;

	modport source (output valid, cell_x, cell_y, cell_z, dist_squared, cells_left,
		empty_flag, status, input ready);
	modport sink (input valid, cell_x, cell_y, cell_z, dist_squared, cells_left,
		empty_flag, status, output ready);
endinterface

[hdl/lcg_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
// No dependencies; used for the visited map, grain store and surface list.
module lcg_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

[hdl/lcg_mod.sv]
// Restoring remainder unit, one dividend bit per cycle.
// Depends on nothing; selects the surface entry for a grow.
module lcg_mod #(
	parameter int DW = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [30:0]   dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] rem
);
	logic [30:0]   shf_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [4:0]    cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;

	assign trial = {rem_q, shf_q[30]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd31;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shf_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			shf_q <= {shf_q[29:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= DW'(trial - {1'b0, div_q});
			end else begin
				rem_q <= DW'(trial);
			end
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;
endmodule

[hdl/lcg_emit.sv]
// Cell formatter: centers the lattice coordinates and forms the squared distance.
// Depends on lcg_pkg; output registered on enable.
module lcg_emit (
	input  logic                clk,
	input  logic                en,
	input  lcg_pkg::coord_t     pos,
	input  logic [4:0]          half,
	output logic signed [4:0]   cx,
	output logic signed [4:0]   cy,
	output logic signed [4:0]   cz,
	output logic [9:0]          sq_dist
);
	import lcg_pkg::*;

	logic signed [5:0]  dx, dy, dz;
	logic signed [11:0] sum;

	assign dx  = $signed({1'b0, pos.x}) - $signed({1'b0, half});
	assign dy  = $signed({1'b0, pos.y}) - $signed({1'b0, half});
	assign dz  = $signed({1'b0, pos.z}) - $signed({1'b0, half});
	assign sum = 12'(dx) * 12'(dx) + 12'(dy) * 12'(dy) + 12'(dz) * 12'(dz);

	always_ff @(posedge clk) begin
		if (en) begin
			cx      <= dx[4:0];
			cy      <= dy[4:0];
			cz      <= dz[4:0];
			sq_dist <= sum[9:0];
		end
	end
endmodule

[hdl/lattice_cluster_growth_core.sv]
// Lattice cluster growth core: top level with sequencer and memories.
// Depends on lcg_pkg, lcg_req_if, lcg_rsp_if, lcg_ram, lcg_mod, lcg_emit.
//
// Usage: commands arrive on req (opcode, random_word), one response per
// transaction leaves on rsp. The user must write half_width via cfg_we/cfg_wdata
// only while idle; the block does not enforce this. A write restarts the cluster.
// A grow picks a surface entry in the remainder unit (the first grow takes
// the centre cell), fetches and places the chosen cell, compacts the
// surface list through its one read and one write port, checks the six
// neighbours and formats the result. Pop and peek read the grain store and
// format the cell; refused items go straight to formatting.
// req.ready is low while an item is in work.
// Reset and every half_width write start a clearing pass over all
// LATTICE_CELLS entries of the visited map, during which req.ready is low.
// The response sits in an output register; the next item is accepted while it
// waits, and a finished item holds in its last step while rsp is stalled.
module lattice_cluster_growth_core #(
	parameter int MAX_HALF_WIDTH = 7,
	parameter int LATTICE_CELLS  = 32768,
	parameter int MAX_CELLS      = 2048,
	parameter int SURFACE_DEPTH  = 16384
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	lcg_req_if.sink    req,
	lcg_rsp_if.source  rsp
);
	import lcg_pkg::*;

	localparam int HMax = calc_max_half(MAX_HALF_WIDTH, LATTICE_CELLS, MAX_CELLS);
	localparam int VA   = $clog2(LATTICE_CELLS);
	localparam int GA   = $clog2(MAX_CELLS);
	localparam int GW   = $clog2(MAX_CELLS + 1);
	localparam int SA   = $clog2(SURFACE_DEPTH);
	localparam int SW   = $clog2(SURFACE_DEPTH + 1);

	state_t state_q, state_d;

	logic [2:0]    half_q;
	logic [VA-1:0] clr_cnt_q;
	logic [SW-1:0] scount_q;
	logic [GW-1:0] grown_q;
	logic [GW-1:0] pop_q;
	logic          complete_q;
	logic [1:0]    op_q;
	coord_t        sel_q;
	logic [VA-1:0] cur_c_q;
	logic [SW-1:0] rd_i_q;
	logic [SW-1:0] wr_k_q;
	logic          pend_q;
	logic [2:0]    dir_q;
	status_t       status_q;
	logic          zero_q;

	logic              out_vld_q;
	logic signed [4:0] ox_q, oy_q, oz_q;
	logic [9:0]        od_q;
	logic [10:0]       ol_q;
	logic              oe_q;
	logic [1:0]        os_q;

	logic [2:0]  h_raw, h_eff;
	logic [4:0]  w, m;
	logic [9:0]  w2;
	logic [10:0] target;

	assign h_raw  = (half_q == 3'd0) ? 3'd1 : half_q;
	assign h_eff  = (h_raw > 3'(HMax)) ? 3'(HMax) : h_raw;
	assign w      = {h_eff, 2'b01};
	assign m      = {1'b0, h_eff, 1'b0};
	assign w2     = side_sq(h_eff);
	assign target = grain_target(h_eff);

	logic          v_we;
	logic [VA-1:0] v_waddr, v_raddr;
	logic          v_wdata, v_rdata;
	logic          g_we;
	logic [GA-1:0] g_waddr, g_raddr;
	coord_t        g_rdata;
	logic          s_we;
	logic [SA-1:0] s_waddr, s_raddr;
	coord_t        s_wdata, s_rdata;

	logic          mod_start, mod_busy;
	logic [SW-1:0] mod_rem;

	logic signed [4:0] ex, ey, ez;
	logic [9:0]        ed;

	logic          accept;
	logic          nb_ok;
	logic [VA:0]   nb_c;
	coord_t        nb_pos;
	logic [GW-1:0] grown_inc;
	logic [GW-1:0] pop_dec;

	assign accept    = req.valid && req.ready;
	assign grown_inc = grown_q + GW'(1);
	assign pop_dec   = pop_q - GW'(1);

	always_comb begin
		nb_pos = sel_q;
		nb_ok  = 1'b0;
		nb_c   = {1'b0, cur_c_q};
		case (dir_q)
			3'd0: begin
				nb_ok    = (sel_q.x + 5'd1) < w;
				nb_pos.x = sel_q.x + 5'd1;
				nb_c     = {1'b0, cur_c_q} + (VA+1)'(1);
			end
			3'd1: begin
				nb_ok    = sel_q.x != 5'd0;
				nb_pos.x = sel_q.x - 5'd1;
				nb_c     = {1'b0, cur_c_q} - (VA+1)'(1);
			end
			3'd2: begin
				nb_ok    = (sel_q.y + 5'd1) < w;
				nb_pos.y = sel_q.y + 5'd1;
				nb_c     = {1'b0, cur_c_q} + (VA+1)'(w);
			end
			3'd3: begin
				nb_ok    = sel_q.y != 5'd0;
				nb_pos.y = sel_q.y - 5'd1;
				nb_c     = {1'b0, cur_c_q} - (VA+1)'(w);
			end
			3'd4: begin
				nb_ok    = (sel_q.z + 5'd1) < w;
				nb_pos.z = sel_q.z + 5'd1;
				nb_c     = {1'b0, cur_c_q} + (VA+1)'(w2);
			end
			3'd5: begin
				nb_ok    = sel_q.z != 5'd0;
				nb_pos.z = sel_q.z - 5'd1;
				nb_c     = {1'b0, cur_c_q} - (VA+1)'(w2);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else if (cfg_we) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		mod_start = 1'b0;
		v_we      = 1'b0;
		v_waddr   = cur_c_q;
		v_wdata   = 1'b1;
		v_raddr   = nb_c[VA-1:0];
		g_we      = 1'b0;
		g_waddr   = grown_q[GA-1:0];
		g_raddr   = pop_dec[GA-1:0];
		s_we      = 1'b0;
		s_waddr   = wr_k_q[SA-1:0];
		s_wdata   = s_rdata;
		s_raddr   = rd_i_q[SA-1:0];
		case (state_q)
			S_CLEAR: begin
				v_we    = 1'b1;
				v_waddr = clr_cnt_q;
				v_wdata = 1'b0;
				if (clr_cnt_q == VA'(LATTICE_CELLS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req.ready = 1'b1;
				if (accept) begin
					if (req.opcode == OP_GROW) begin
						if (complete_q || (grown_q != '0 && scount_q == '0)) begin
							state_d = S_EMIT;
						end else if (grown_q == '0) begin
							state_d = S_LIN;
						end else begin
							mod_start = 1'b1;
							state_d   = S_MOD;
						end
					end else if (!complete_q || pop_q == '0) begin
						state_d = S_EMIT;
					end else begin
						state_d = S_POP_WT;
					end
				end
			end
			S_MOD: begin
				s_raddr = mod_rem[SA-1:0];
				if (!mod_busy) begin
					state_d = S_PICK_WT;
				end
			end
			S_PICK_WT: state_d = S_LIN;
			S_LIN:     state_d = S_LIN2;
			S_LIN2:    state_d = S_PLACE;
			S_PLACE: begin
				v_we    = 1'b1;
				g_we    = grown_q < GW'(MAX_CELLS);
				state_d = S_CMP;
			end
			S_CMP: begin
				if (pend_q && s_rdata != sel_q) begin
					s_we = 1'b1;
				end
				if (rd_i_q == scount_q && !pend_q) begin
					state_d = S_NB_RD;
				end
			end
			S_NB_RD: begin
				if (nb_ok) begin
					state_d = S_NB_WR;
				end else if (dir_q == 3'd5) begin
					state_d = S_EMIT;
				end
			end
			S_NB_WR: begin
				s_waddr = scount_q[SA-1:0];
				s_wdata = nb_pos;
				s_we    = !v_rdata && scount_q < SW'(SURFACE_DEPTH);
				state_d = (dir_q == 3'd5) ? S_EMIT : S_NB_RD;
			end
			S_POP_WT: state_d = S_EMIT;
			S_EMIT:   state_d = S_FIN;
			S_FIN: begin
				if (!out_vld_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q     <= 3'd1;
			clr_cnt_q  <= '0;
			scount_q   <= '0;
			grown_q    <= '0;
			pop_q      <= '0;
			complete_q <= 1'b0;
			pend_q     <= 1'b0;
			rd_i_q     <= '0;
			wr_k_q     <= '0;
			dir_q      <= '0;
		end else if (cfg_we) begin
			half_q     <= cfg_wdata;
			clr_cnt_q  <= '0;
			scount_q   <= '0;
			grown_q    <= '0;
			pop_q      <= '0;
			complete_q <= 1'b0;
			pend_q     <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: clr_cnt_q <= clr_cnt_q + VA'(1);
				S_POP_WT: begin
					if (op_q == OP_POP) begin
						pop_q <= pop_dec;
					end
				end
				S_PLACE: begin
					grown_q <= grown_inc;
					rd_i_q  <= '0;
					wr_k_q  <= '0;
					pend_q  <= 1'b0;
					dir_q   <= '0;
					if (!complete_q && grown_inc >= GW'(target)) begin
						complete_q <= 1'b1;
						pop_q      <= grown_inc;
					end
				end
				S_CMP: begin
					if (rd_i_q != scount_q) begin
						rd_i_q <= rd_i_q + SW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && s_rdata != sel_q) begin
						wr_k_q <= wr_k_q + SW'(1);
					end
					if (rd_i_q == scount_q && !pend_q) begin
						scount_q <= wr_k_q;
					end
				end
				S_NB_RD: begin
					if (!nb_ok) begin
						dir_q <= dir_q + 3'd1;
					end
				end
				S_NB_WR: begin
					dir_q <= dir_q + 3'd1;
					if (s_we) begin
						scount_q <= scount_q + SW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q   <= req.opcode;
					zero_q <= 1'b1;
					sel_q  <= '{z: m, y: m, x: m};
					if (req.opcode == OP_GROW) begin
						status_q <= STS_REFUSED;
						if (!complete_q && (grown_q == '0 || scount_q != '0)) begin
							status_q <= STS_OK;
							zero_q   <= 1'b0;
						end
					end else if (!complete_q) begin
						status_q <= STS_NOTDONE;
					end else if (pop_q == '0) begin
						status_q <= STS_EMPTY;
					end else begin
						status_q <= STS_OK;
						zero_q   <= 1'b0;
					end
				end
			end
			S_PICK_WT: sel_q <= s_rdata;
			S_LIN:     cur_c_q <= VA'({5'd0, sel_q.x} + 10'(w) * 10'(sel_q.y));
			S_LIN2:    cur_c_q <= VA'((VA+1)'(cur_c_q) + (VA+1)'(w2) * (VA+1)'(sel_q.z));
			S_POP_WT:  sel_q <= g_rdata;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_FIN && (!out_vld_q || rsp.ready)) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_vld_q || rsp.ready)) begin
			ox_q <= zero_q ? 5'sd0 : ex;
			oy_q <= zero_q ? 5'sd0 : ey;
			oz_q <= zero_q ? 5'sd0 : ez;
			od_q <= zero_q ? 10'd0 : ed;
			ol_q <= complete_q ? 11'(pop_q) : 11'd0;
			oe_q <= complete_q && pop_q == '0;
			os_q <= status_q;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.cell_x       = ox_q;
	assign rsp.cell_y       = oy_q;
	assign rsp.cell_z       = oz_q;
	assign rsp.dist_squared = od_q;
	assign rsp.cells_left   = ol_q;
	assign rsp.empty_flag   = oe_q;
	assign rsp.status       = os_q;

	lcg_ram #(.WIDTH(1), .DEPTH(LATTICE_CELLS)) u_visited (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	lcg_ram #(.WIDTH($bits(coord_t)), .DEPTH(MAX_CELLS)) u_grain (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (sel_q),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	lcg_ram #(.WIDTH($bits(coord_t)), .DEPTH(SURFACE_DEPTH)) u_surface (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	lcg_mod #(.DW(SW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (req.random_word),
		.divisor  (scount_q),
		.busy     (mod_busy),
		.rem      (mod_rem)
	);

	lcg_emit u_emit (
		.clk     (clk),
		.en      (state_q == S_EMIT),
		.pos     (sel_q),
		.half    (m),
		.cx      (ex),
		.cy      (ey),
		.cz      (ez),
		.sq_dist (ed)
	);

	a_pop_le_grown: assert property (@(posedge clk) disable iff (!arst_n)
		pop_q <= grown_q)
		else $error("pop head beyond grown count");

	a_complete_count: assert property (@(posedge clk) disable iff (!arst_n)
		complete_q |-> grown_q == GW'(target))
		else $error("complete grain with wrong cell count");

	a_surface_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scount_q <= SW'(SURFACE_DEPTH))
		else $error("surface count beyond depth");

endmodule
